### src/fdia_pkg.sv
// Shared types, codes and defaults for the fence deferred index allocator.
`default_nettype none

package fdia_pkg;

    localparam int unsigned INDEX_BITS_DEF    = 16;
    localparam int unsigned FREE_DEPTH_DEF    = 1024;
    localparam int unsigned RETIRED_DEPTH_DEF = 1024;
    localparam int unsigned FENCE_BITS_DEF    = 64;

    localparam int unsigned CFG_BITS        = 17;
    localparam logic [CFG_BITS-1:0] HEAP_SIZE_RESET = 17'd65536;

    typedef enum logic [1:0] {
        MODE_TRANSIENT = 2'd0,
        MODE_RETIRE    = 2'd1,
        MODE_PERMANENT = 2'd2,
        MODE_RECLAIM   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        STAT_REUSED   = 3'd0,
        STAT_HEAP     = 3'd1,
        STAT_OVERFLOW = 3'd2,
        STAT_IGNORED  = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_DONE     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        GSEL_NONE,
        GSEL_STACK,
        GSEL_BUMP
    } t_gsel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RECLAIM,
        S_GRANT,
        S_EXEC,
        S_DONE
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] index;
        logic        index_valid;
        logic [63:0] retire_fence;
        logic [63:0] done_fence;
    } t_in_item;

    typedef struct packed {
        logic [15:0] granted_index;
        t_status     status;
        logic [10:0] reclaimed_count;
        logic [10:0] free_count;
        logic [10:0] retired_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch;
        logic    rcl_move;
        logic    fs_pop;
        logic    fs_push;
        logic    rq_push;
        logic    set_res;
        t_gsel   gsel;
        t_status code;
        logic    load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_mode mode;
        logic  index_valid;
        logic  rfence_zero;
        logic  fill_nz;
        logic  ripe;
        logic  stack_full;
        logic  stack_empty;
        logic  rq_full;
        logic  bump_ok;
        logic  out_free;
    } t_stat;

endpackage

`default_nettype wire

### src/fdia_ctrl.sv
// Controller state machine that sequences each allocator item.
`default_nettype none

module fdia_ctrl
    import fdia_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_in_valid,
    input  t_mode  i_in_mode,
    output logic   o_in_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.gsel = GSEL_NONE;
        o_cmd.code = STAT_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    if (i_in_mode == MODE_TRANSIENT || i_in_mode == MODE_RECLAIM) begin
                        n_state = S_RECLAIM;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_RECLAIM: begin
                if (i_stat.fill_nz && i_stat.ripe && !i_stat.stack_full) begin
                    o_cmd.rcl_move = 1'b1;
                end else if (i_stat.mode == MODE_RECLAIM) begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.fill_nz && i_stat.ripe) begin
                        o_cmd.code = STAT_FULL;
                    end
                    n_state       = S_DONE;
                end else if (!i_stat.stack_empty) begin
                    o_cmd.fs_pop = 1'b1;
                    n_state      = S_GRANT;
                end else begin
                    o_cmd.set_res = 1'b1;
                    if (i_stat.bump_ok) begin
                        o_cmd.gsel = GSEL_BUMP;
                        o_cmd.code = STAT_HEAP;
                    end else begin
                        o_cmd.code = STAT_OVERFLOW;
                    end
                    n_state = S_DONE;
                end
            end
            S_GRANT: begin
                o_cmd.set_res = 1'b1;
                o_cmd.gsel    = GSEL_STACK;
                o_cmd.code    = STAT_REUSED;
                n_state       = S_DONE;
            end
            S_EXEC: begin
                o_cmd.set_res = 1'b1;
                if (i_stat.mode == MODE_RETIRE) begin
                    priority if (!i_stat.index_valid) begin
                        o_cmd.code = STAT_IGNORED;
                    end else if (i_stat.rfence_zero) begin
                        if (i_stat.stack_full) begin
                            o_cmd.code = STAT_FULL;
                        end else begin
                            o_cmd.fs_push = 1'b1;
                        end
                    end else if (i_stat.rq_full) begin
                        o_cmd.code = STAT_FULL;
                    end else begin
                        o_cmd.rq_push = 1'b1;
                    end
                end else if (i_stat.bump_ok) begin
                    o_cmd.gsel = GSEL_BUMP;
                    o_cmd.code = STAT_HEAP;
                end else begin
                    o_cmd.code = STAT_OVERFLOW;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/fdia_dp.sv
// Datapath: bump pointer, free stack, retired queue and result register.
`default_nettype none

module fdia_dp
    import fdia_pkg::*;
#(
    parameter int unsigned INDEX_BITS    = INDEX_BITS_DEF,
    parameter int unsigned FREE_DEPTH    = FREE_DEPTH_DEF,
    parameter int unsigned RETIRED_DEPTH = RETIRED_DEPTH_DEF,
    parameter int unsigned FENCE_BITS    = FENCE_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire [CFG_BITS-1:0]   i_cfg_data,
    input  t_in_item             i_in_item,
    output t_out_item            o_out_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int unsigned FAW = $clog2(FREE_DEPTH);
    localparam int unsigned TW  = $clog2(FREE_DEPTH + 1);
    localparam int unsigned RAW = $clog2(RETIRED_DEPTH);
    localparam int unsigned RFW = $clog2(RETIRED_DEPTH + 1);
    localparam int unsigned NW  = INDEX_BITS + 1;
    localparam int unsigned CW  = (NW > CFG_BITS) ? NW : CFG_BITS;
    localparam int unsigned EW  = INDEX_BITS + FENCE_BITS;

    logic [CFG_BITS-1:0]   r_heap_size;
    logic [NW-1:0]         r_next_fresh;
    logic [TW-1:0]         r_free_top;
    logic [RAW-1:0]        r_head;
    logic [RFW-1:0]        r_fill;
    logic [RFW-1:0]        r_moved;
    t_mode                 r_mode;
    logic [INDEX_BITS-1:0] r_index;
    logic                  r_index_valid;
    logic [FENCE_BITS-1:0] r_rfence;
    logic [FENCE_BITS-1:0] r_done;
    logic [INDEX_BITS-1:0] r_grant;
    t_status               r_status;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic [INDEX_BITS-1:0] r_fs_mem [FREE_DEPTH];
    logic [INDEX_BITS-1:0] r_fs_rdata;
    logic [EW-1:0]         r_rq_mem [RETIRED_DEPTH];
    logic [EW-1:0]         r_rq_rdata;

    logic [31:0]           in_index_ext;
    logic [INDEX_BITS-1:0] rq_idx;
    logic [FENCE_BITS-1:0] rq_fence;
    logic [RAW-1:0]        head_inc;
    logic [RAW-1:0]        rq_raddr;
    logic [RAW:0]          tail_sum;
    logic [RAW-1:0]        tail;
    logic [FAW-1:0]        fs_waddr;
    logic [FAW-1:0]        fs_raddr;
    logic                  fs_we;
    logic [INDEX_BITS-1:0] fs_wdata;
    logic [31:0]           grant_ext;
    logic [31:0]           moved_ext;
    logic [31:0]           top_ext;
    logic [31:0]           fill_ext;

    assign in_index_ext = 32'(i_in_item.index);
    assign rq_idx       = r_rq_rdata[EW-1:FENCE_BITS];
    assign rq_fence     = r_rq_rdata[FENCE_BITS-1:0];

    assign head_inc = (r_head == RAW'(RETIRED_DEPTH - 1)) ? '0 : r_head + 1'b1;
    // The read runs one entry ahead while entries are being moved, so the
    // registered data always belongs to the current head.
    assign rq_raddr = i_cmd.rcl_move ? head_inc : r_head;
    assign tail_sum = {1'b0, r_head} + (RAW + 1)'(r_fill);
    assign tail     = (tail_sum >= (RAW + 1)'(RETIRED_DEPTH))
                    ? RAW'(tail_sum - (RAW + 1)'(RETIRED_DEPTH)) : RAW'(tail_sum);

    assign fs_we    = i_cmd.rcl_move | i_cmd.fs_push;
    assign fs_wdata = i_cmd.rcl_move ? rq_idx : r_index;
    assign fs_waddr = FAW'(r_free_top);
    assign fs_raddr = (r_free_top == '0) ? '0 : FAW'(r_free_top - 1'b1);

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_fs_mem[fs_waddr] <= fs_wdata;
        end
        r_fs_rdata <= r_fs_mem[fs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rq_push) begin
            r_rq_mem[tail] <= {r_index, r_rfence};
        end
        r_rq_rdata <= r_rq_mem[rq_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_size  <= HEAP_SIZE_RESET;
            r_next_fresh <= '0;
            r_free_top   <= '0;
            r_head       <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_heap_size <= i_cfg_data;
            end
            if (i_cmd.rcl_move) begin
                r_head <= head_inc;
                r_fill <= r_fill - 1'b1;
            end else if (i_cmd.rq_push) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.rcl_move || i_cmd.fs_push) begin
                r_free_top <= r_free_top + 1'b1;
            end else if (i_cmd.fs_pop) begin
                r_free_top <= r_free_top - 1'b1;
            end
            if (i_cmd.set_res && i_cmd.gsel == GSEL_BUMP) begin
                r_next_fresh <= r_next_fresh + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign grant_ext = 32'(r_grant);
    assign moved_ext = 32'(r_moved);
    assign top_ext   = 32'(r_free_top);
    assign fill_ext  = 32'(r_fill);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode        <= i_in_item.mode;
            r_index       <= in_index_ext[INDEX_BITS-1:0];
            r_index_valid <= i_in_item.index_valid;
            r_rfence      <= i_in_item.retire_fence[FENCE_BITS-1:0];
            r_done        <= i_in_item.done_fence[FENCE_BITS-1:0];
            r_moved       <= '0;
        end else if (i_cmd.rcl_move) begin
            r_moved <= r_moved + 1'b1;
        end
        if (i_cmd.set_res) begin
            r_status <= i_cmd.code;
            unique case (i_cmd.gsel)
                GSEL_STACK: r_grant <= r_fs_rdata;
                GSEL_BUMP:  r_grant <= r_next_fresh[INDEX_BITS-1:0];
                default:    r_grant <= '0;
            endcase
        end
        if (i_cmd.load_out) begin
            r_out.granted_index   <= grant_ext[15:0];
            r_out.status          <= r_status;
            r_out.reclaimed_count <= moved_ext[10:0];
            r_out.free_count      <= top_ext[10:0];
            r_out.retired_count   <= fill_ext[10:0];
        end
    end

    assign o_out_item  = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.mode        = r_mode;
        o_stat.index_valid = r_index_valid;
        o_stat.rfence_zero = (r_rfence == '0);
        o_stat.fill_nz     = (r_fill != '0);
        o_stat.ripe        = (rq_fence <= r_done);
        o_stat.stack_full  = (r_free_top == TW'(FREE_DEPTH));
        o_stat.stack_empty = (r_free_top == '0);
        o_stat.rq_full     = (r_fill == RFW'(RETIRED_DEPTH));
        // The pointer saturates at 2^INDEX_BITS, so its top bit marks that limit.
        o_stat.bump_ok     = !r_next_fresh[INDEX_BITS]
                           && (CW'(r_next_fresh) < CW'(r_heap_size));
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

endmodule

`default_nettype wire

### src/fence_deferred_index_allocator_core.sv
// Sequence: retire and permanent allocate go from accept through the execute state
// to the done state; transient allocate first moves ripe retired entries to the free
// stack in the reclaim state, one per cycle, then reuses a free stack entry through
// the grant state or tries a fresh index, and reclaim-only does the moves alone.
// A new item is accepted only once the previous result is in the output register,
// where it waits while the next item is accepted. Reset clears the pointers and
// counts and sets heap_size to 65536; the stack and queue memories are not cleared.
`default_nettype none

module fence_deferred_index_allocator_core
    import fdia_pkg::*;
#(
    parameter int unsigned INDEX_BITS    = INDEX_BITS_DEF,
    parameter int unsigned FREE_DEPTH    = FREE_DEPTH_DEF,
    parameter int unsigned RETIRED_DEPTH = RETIRED_DEPTH_DEF,
    parameter int unsigned FENCE_BITS    = FENCE_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [CFG_BITS-1:0]  i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output t_out_item           o_out_item
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    fdia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_item.mode),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fdia_dp #(
        .INDEX_BITS    (INDEX_BITS),
        .FREE_DEPTH    (FREE_DEPTH),
        .RETIRED_DEPTH (RETIRED_DEPTH),
        .FENCE_BITS    (FENCE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire
